[hw/rtl/jbt_pkg.sv]
package jbt_pkg;

    // scanner modes
    typedef enum logic [2:0] {
        MODE_STRUCT = 3'd0,
        MODE_BARE   = 3'd1,
        MODE_STRING = 3'd2,
        MODE_UTF8   = 3'd3,
        MODE_ESC    = 3'd4
    } t_mode;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

endpackage

[hw/rtl/jbt_scan.sv]
module jbt_scan #(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic [7:0]            i_data_byte,
    input  logic                  i_first_byte,
    input  jbt_pkg::t_mode        i_mode,
    input  logic [DEPTH_BITS-1:0] i_depth,
    input  logic [1:0]            i_utf8_left,
    input  logic [POS_BITS-1:0]   i_pos,
    input  logic [POS_BITS-1:0]   i_mark,
    input  logic                  i_err,
    output jbt_pkg::t_mode        o_mode,
    output logic [DEPTH_BITS-1:0] o_depth,
    output logic [1:0]            o_utf8_left,
    output logic [POS_BITS-1:0]   o_pos,
    output logic [POS_BITS-1:0]   o_mark,
    output logic                  o_err,
    output logic                  o_cap_valid,
    output logic [POS_BITS-1:0]   o_cap_start,
    output logic [POS_BITS-1:0]   o_cap_len
);

    localparam logic [DEPTH_BITS-1:0] DepthMax = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DepthOne = DEPTH_BITS'(1);
    localparam logic [DEPTH_BITS-1:0] DepthZero = '0;

    jbt_pkg::t_mode        cur_mode;
    logic [DEPTH_BITS-1:0] cur_depth;
    logic [1:0]            cur_left;
    logic [POS_BITS-1:0]   cur_pos;
    logic [POS_BITS-1:0]   cur_mark;
    logic                  cur_err;
    logic                  do_struct;
    logic [POS_BITS-1:0]   mark_s;
    logic                  bare_term;
    logic                  bare_ok;

    // a new document starts from the reset state
    assign cur_mode  = i_first_byte ? jbt_pkg::MODE_STRUCT : i_mode;
    assign cur_depth = i_first_byte ? DepthZero : i_depth;
    assign cur_left  = i_first_byte ? 2'd0 : i_utf8_left;
    assign cur_pos   = i_first_byte ? '0 : i_pos;
    assign cur_mark  = i_first_byte ? '0 : i_mark;
    assign cur_err   = i_first_byte ? 1'b0 : i_err;

    assign o_pos = cur_pos + POS_BITS'(1);

    assign bare_term = (i_data_byte == jbt_pkg::CH_TAB) || (i_data_byte == jbt_pkg::CH_SPACE)
                    || (i_data_byte == jbt_pkg::CH_CR) || (i_data_byte == jbt_pkg::CH_LF)
                    || (i_data_byte == jbt_pkg::CH_COMMA)
                    || (i_data_byte == jbt_pkg::CH_RBRACK)
                    || (i_data_byte == jbt_pkg::CH_RBRACE);
    assign bare_ok = (i_data_byte >= 8'h21) && (i_data_byte <= 8'h7E)
                  && (i_data_byte != jbt_pkg::CH_BTICK);

    always_comb begin
        o_mode      = cur_mode;
        o_depth     = cur_depth;
        o_utf8_left = cur_left;
        o_mark      = cur_mark;
        o_err       = cur_err;
        o_cap_valid = 1'b0;
        o_cap_start = '0;
        o_cap_len   = '0;
        do_struct   = 1'b0;
        mark_s      = cur_mark;

        if (!cur_err) begin
            case (cur_mode)
                jbt_pkg::MODE_STRUCT: begin
                    do_struct = 1'b1;
                end
                jbt_pkg::MODE_BARE: begin
                    if (bare_term) begin
                        // literal ends before this byte; byte is then rescanned as structure
                        if (cur_depth == DepthOne) begin
                            o_cap_valid = 1'b1;
                            o_cap_start = cur_mark;
                            o_cap_len   = cur_pos - cur_mark;
                            mark_s      = cur_pos - POS_BITS'(1);
                            o_mark      = mark_s;
                        end
                        o_mode    = jbt_pkg::MODE_STRUCT;
                        do_struct = 1'b1;
                    end else if (!bare_ok) begin
                        o_err = 1'b1;
                    end
                end
                jbt_pkg::MODE_STRING: begin
                    if (i_data_byte == jbt_pkg::CH_QUOTE) begin
                        if (cur_depth == DepthOne) begin
                            o_cap_valid = 1'b1;
                            o_cap_start = cur_mark;
                            o_cap_len   = cur_pos - cur_mark;
                            o_mark      = cur_pos - POS_BITS'(1);
                        end
                        o_mode = jbt_pkg::MODE_STRUCT;
                    end else if (i_data_byte == jbt_pkg::CH_BSLASH) begin
                        o_mode = jbt_pkg::MODE_ESC;
                    end else if (i_data_byte >= 8'h20 && i_data_byte <= 8'h7E) begin
                        o_mode = cur_mode;
                    end else if (i_data_byte >= 8'hC0 && i_data_byte <= 8'hDF) begin
                        o_mode      = jbt_pkg::MODE_UTF8;
                        o_utf8_left = 2'd1;
                    end else if (i_data_byte >= 8'hE0 && i_data_byte <= 8'hEF) begin
                        o_mode      = jbt_pkg::MODE_UTF8;
                        o_utf8_left = 2'd2;
                    end else if (i_data_byte >= 8'hF0 && i_data_byte <= 8'hF7) begin
                        o_mode      = jbt_pkg::MODE_UTF8;
                        o_utf8_left = 2'd3;
                    end else begin
                        o_err = 1'b1;
                    end
                end
                jbt_pkg::MODE_UTF8: begin
                    if (i_data_byte >= 8'h80 && i_data_byte <= 8'hBF) begin
                        o_utf8_left = cur_left - 2'd1;
                        if (cur_left == 2'd1) begin
                            o_mode = jbt_pkg::MODE_STRING;
                        end
                    end else begin
                        o_err = 1'b1;
                    end
                end
                jbt_pkg::MODE_ESC: begin
                    case (i_data_byte) inside
                        jbt_pkg::CH_QUOTE, jbt_pkg::CH_BSLASH, jbt_pkg::CH_SLASH,
                        jbt_pkg::CH_LOW_B, jbt_pkg::CH_LOW_F, jbt_pkg::CH_LOW_N,
                        jbt_pkg::CH_LOW_R, jbt_pkg::CH_LOW_T, jbt_pkg::CH_LOW_U: begin
                            o_mode = jbt_pkg::MODE_STRING;
                        end
                        default: begin
                            o_err = 1'b1;
                        end
                    endcase
                end
                default: begin
                    o_err = 1'b1;
                end
            endcase

            if (do_struct) begin
                case (i_data_byte) inside
                    jbt_pkg::CH_TAB, jbt_pkg::CH_SPACE, jbt_pkg::CH_CR, jbt_pkg::CH_LF,
                    jbt_pkg::CH_COLON, jbt_pkg::CH_COMMA: begin
                        o_depth = cur_depth;
                    end
                    jbt_pkg::CH_QUOTE: begin
                        if (cur_depth == DepthOne) begin
                            o_mark = cur_pos + POS_BITS'(1);
                        end
                        o_mode = jbt_pkg::MODE_STRING;
                    end
                    jbt_pkg::CH_LBRACK, jbt_pkg::CH_LBRACE: begin
                        if (cur_depth == DepthMax) begin
                            o_err = 1'b1;
                        end else begin
                            if (cur_depth == DepthOne) begin
                                o_mark = cur_pos;
                            end
                            o_depth = cur_depth + DepthOne;
                        end
                    end
                    jbt_pkg::CH_RBRACK, jbt_pkg::CH_RBRACE: begin
                        if (cur_depth == DepthZero) begin
                            o_err = 1'b1;
                        end else begin
                            o_depth = cur_depth - DepthOne;
                            // container closing back to depth one is captured whole
                            if (cur_depth == DEPTH_BITS'(2)) begin
                                o_cap_valid = 1'b1;
                                o_cap_start = mark_s;
                                o_cap_len   = cur_pos - mark_s + POS_BITS'(1);
                                o_mark      = cur_pos;
                            end
                        end
                    end
                    [8'h30:8'h39], jbt_pkg::CH_MINUS, jbt_pkg::CH_LOW_T, jbt_pkg::CH_LOW_F,
                    jbt_pkg::CH_LOW_N: begin
                        if (cur_depth == DepthOne) begin
                            o_mark = cur_pos;
                        end
                        o_mode = jbt_pkg::MODE_BARE;
                    end
                    default: begin
                        o_err = 1'b1;
                    end
                endcase
            end
        end
    end

endmodule

[hw/rtl/json_byte_tokenizer.sv]
// Channel  Direction  Handshake          Payload
// in       request    i_valid / o_stall  i_data_byte, i_first_byte, i_last_byte
// out      result     o_valid / i_stall  o_capture_*, o_parse_error, o_doc_done, o_end_depth
//
// One byte per cycle sustained while the output is not stalled; each request passes the input
// register, then scanner logic into the result register.
// Scanner state updates in the same cycle the byte moves to the result register.
// Synchronous active-low reset clears scanner state and both stages.
// Output stall holds the result register; the input register still takes one byte while the result waits.
module json_byte_tokenizer #(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_capture_valid,
    output logic [15:0] o_capture_start,
    output logic [15:0] o_capture_length,
    output logic        o_parse_error,
    output logic        o_doc_done,
    output logic [7:0]  o_end_depth
);

    localparam int ExtW = DEPTH_BITS + 8;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_first;
    logic                  r_in_last;

    jbt_pkg::t_mode        r_mode;
    logic [DEPTH_BITS-1:0] r_depth;
    logic [1:0]            r_utf8_left;
    logic [POS_BITS-1:0]   r_pos;
    logic [POS_BITS-1:0]   r_mark;
    logic                  r_err;

    jbt_pkg::t_mode        n_mode;
    logic [DEPTH_BITS-1:0] n_depth;
    logic [1:0]            n_utf8_left;
    logic [POS_BITS-1:0]   n_pos;
    logic [POS_BITS-1:0]   n_mark;
    logic                  n_err;
    logic                  n_cap_valid;
    logic [POS_BITS-1:0]   n_cap_start;
    logic [POS_BITS-1:0]   n_cap_len;

    logic                  r_out_valid;
    logic                  r_cap_valid;
    logic [15:0]           r_cap_start;
    logic [15:0]           r_cap_len;
    logic                  r_perr;
    logic                  r_done;
    logic [7:0]            r_end_depth;

    logic                  fire;
    logic [ExtW-1:0]       depth_ext;
    logic [7:0]            depth_sat;

    assign fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !fire;

    jbt_scan #(
        .POS_BITS   (POS_BITS),
        .DEPTH_BITS (DEPTH_BITS)
    ) u_scan (
        .i_data_byte  (r_in_byte),
        .i_first_byte (r_in_first),
        .i_mode       (r_mode),
        .i_depth      (r_depth),
        .i_utf8_left  (r_utf8_left),
        .i_pos        (r_pos),
        .i_mark       (r_mark),
        .i_err        (r_err),
        .o_mode       (n_mode),
        .o_depth      (n_depth),
        .o_utf8_left  (n_utf8_left),
        .o_pos        (n_pos),
        .o_mark       (n_mark),
        .o_err        (n_err),
        .o_cap_valid  (n_cap_valid),
        .o_cap_start  (n_cap_start),
        .o_cap_len    (n_cap_len)
    );

    assign depth_ext = ExtW'(n_depth);
    assign depth_sat = (depth_ext > ExtW'(255)) ? 8'hFF : depth_ext[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= jbt_pkg::MODE_STRUCT;
            r_depth     <= '0;
            r_utf8_left <= 2'd0;
            r_pos       <= '0;
            r_mark      <= '0;
            r_err       <= 1'b0;
        end else begin
            if (!r_in_valid || fire) begin
                r_in_valid <= i_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_mode      <= n_mode;
                r_depth     <= n_depth;
                r_utf8_left <= n_utf8_left;
                r_pos       <= n_pos;
                r_mark      <= n_mark;
                r_err       <= n_err;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && (!r_in_valid || fire)) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_byte;
            r_in_last  <= i_last_byte;
        end
        if (fire) begin
            r_cap_valid <= n_cap_valid;
            r_cap_start <= 16'(n_cap_start);
            r_cap_len   <= 16'(n_cap_len);
            r_perr      <= n_err;
            r_done      <= r_in_last;
            r_end_depth <= r_in_last ? depth_sat : 8'd0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_capture_valid  = r_cap_valid;
    assign o_capture_start  = r_cap_start;
    assign o_capture_length = r_cap_len;
    assign o_parse_error    = r_perr;
    assign o_doc_done       = r_done;
    assign o_end_depth      = r_end_depth;

    // a capture never coincides with a set error flag
    a_cap_no_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_capture_valid |-> !o_parse_error)
        else $error("capture reported with error set");

    a_cap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_capture_valid |-> o_capture_start == 16'd0 && o_capture_length == 16'd0)
        else $error("capture fields not cleared");

    a_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_doc_done |-> o_end_depth == 8'd0)
        else $error("end depth set before last byte");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_out_valid && i_stall && r_in_valid)
        else $error("input stalled without output back-pressure");

endmodule
